// ----- design/srhp_pkg.sv -----
// Shared types and constants for the stepper rail homing positioner.
// No dependencies; every other file uses this package.
`default_nettype none

package srhp_pkg;

  localparam int unsigned PosBitsDefault = 32;
  localparam int unsigned VelW = 24;
  localparam int unsigned SpdW = 23;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [SpdW-1:0] BackoffSpeed = 23'd10000;

  typedef enum logic [3:0] {
    PH_SETUP       = 4'd0,
    PH_BACKOFF     = 4'd1,
    PH_ARM         = 4'd2,
    PH_SEEK        = 4'd3,
    PH_STOPPED     = 4'd4,
    PH_TO_RECEIVE  = 4'd5,
    PH_AT_RECEIVE  = 4'd6,
    PH_TO_SQUISH   = 4'd7,
    PH_AT_SQUISH   = 4'd8,
    PH_TO_CORE     = 4'd9,
    PH_AT_CORE     = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_RECEIVE = 2'd1,
    ST_SQUISH  = 2'd2,
    ST_CORE    = 2'd3
  } station_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RECEIVE_TARGET = 3'd0,
    REG_SQUISH_TARGET  = 3'd1,
    REG_CORE_TARGET    = 3'd2,
    REG_BACKOFF_STEPS  = 3'd3,
    REG_HOMING_SPEED   = 3'd4,
    REG_TRAVEL_SPEED   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic select_a;
    logic select_b;
    logic driver_ready;
    logic target_reached;
    logic speed_reached;
    logic stall_seen;
  } status_t;

  // Single-bit command flags of one result word.
  typedef struct packed {
    logic move_issue;
    logic velocity_issue;
    logic stall_arm_issue;
    logic stall_arm_value;
    logic zero_issue;
  } cmd_flags_t;

endpackage

`default_nettype wire

// ----- design/srhp_if.sv -----
// Valid/ready channel interfaces: input word, result word, register write.
// Depends on srhp_pkg for field widths.
`default_nettype none

interface srhp_in_if #(
  parameter int unsigned POS_BITS = srhp_pkg::PosBitsDefault
);
  logic                       valid;
  logic                       ready;
  logic                       select_a;
  logic                       select_b;
  logic                       driver_ready;
  logic                       target_reached;
  logic                       speed_reached;
  logic                       stall_seen;
  logic signed [POS_BITS-1:0] actual_position;

  modport source (output valid, select_a, select_b, driver_ready, target_reached,
                  speed_reached, stall_seen, actual_position, input ready);
  modport sink (input valid, select_a, select_b, driver_ready, target_reached,
                speed_reached, stall_seen, actual_position, output ready);
endinterface

interface srhp_out_if #(
  parameter int unsigned POS_BITS = srhp_pkg::PosBitsDefault
);
  logic                              valid;
  logic                              ready;
  logic [3:0]                        phase;
  logic                              move_issue;
  logic signed [POS_BITS-1:0]        move_target;
  logic [srhp_pkg::SpdW-1:0]         move_speed_limit;
  logic                              velocity_issue;
  logic signed [srhp_pkg::VelW-1:0]  velocity_value;
  logic                              stall_arm_issue;
  logic                              stall_arm_value;
  logic                              zero_issue;

  modport source (output valid, phase, move_issue, move_target, move_speed_limit,
                  velocity_issue, velocity_value, stall_arm_issue, stall_arm_value,
                  zero_issue, input ready);
  modport sink (input valid, phase, move_issue, move_target, move_speed_limit,
                velocity_issue, velocity_value, stall_arm_issue, stall_arm_value,
                zero_issue, output ready);
endinterface

interface srhp_cfg_if #(
  parameter int unsigned DATA_W = srhp_pkg::PosBitsDefault
);
  logic                          valid;
  logic                          ready;
  logic [srhp_pkg::CfgIdxW-1:0]  index;
  logic [DATA_W-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/stepper_rail_homing_positioner_core.sv -----
// Stepper rail homing positioner: input register, sequencer, result register.
// Depends on srhp_pkg, srhp_if, srhp_cfg and srhp_step.
//
// Usage: one status word per control tick enters on in_i (switches, driver
// flags, actual position); one result word per input leaves on out_o with the
// phase after the step and any move, velocity, stall-arm or zero command.
// Unissued command fields read zero. Registers are written on cfg_i (index
// 0..5: receive, squish, core targets, backoff offset, homing speed, travel
// speed); cfg_i is always ready, and writes are expected only while idle.
// Path: a word accepted on in_i is held in the input register, stepped by
// the combinational sequencer and written to the result register for out_o.
// Throughput: one word per cycle while out_o is ready. Reset clears the
// phase to setup, the station request to none and all configuration
// registers to zero. When out_o stalls, the result register holds and the
// input register can still take one word; in_i.ready drops only when both
// registers are full.
`default_nettype none

module stepper_rail_homing_positioner_core #(
  parameter int unsigned POS_BITS = srhp_pkg::PosBitsDefault,
  parameter int unsigned CFG_W    = (POS_BITS > srhp_pkg::VelW) ? POS_BITS : srhp_pkg::VelW
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  srhp_in_if.sink    in_i,
  srhp_out_if.source out_o,
  srhp_cfg_if.sink   cfg_i
);
  import srhp_pkg::*;

  // Config
  logic signed [POS_BITS-1:0] receive_target, squish_target, core_target, backoff_steps;
  logic signed [VelW-1:0]     homing_speed;
  logic        [SpdW-1:0]     travel_speed;

  srhp_cfg #(.POS_BITS(POS_BITS), .DATA_W(CFG_W)) u_cfg (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_i),
    .receive_target_o     (receive_target),
    .squish_target_o      (squish_target),
    .core_target_o        (core_target),
    .home_backoff_steps_o (backoff_steps),
    .homing_speed_o       (homing_speed),
    .travel_speed_o       (travel_speed)
  );

  // Input register
  logic                       in_valid_q;
  status_t                    status_q;
  logic signed [POS_BITS-1:0] pos_q;
  logic                       out_valid_q;
  logic                       advance;
  logic                       step;

  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      status_q <= '{select_a:       in_i.select_a,
                    select_b:       in_i.select_b,
                    driver_ready:   in_i.driver_ready,
                    target_reached: in_i.target_reached,
                    speed_reached:  in_i.speed_reached,
                    stall_seen:     in_i.stall_seen};
      pos_q    <= in_i.actual_position;
    end
  end

  // Sequencer state
  phase_e   phase_q, phase_d;
  station_e station_q, station_d;
  cmd_flags_t                 flags_d;
  logic signed [POS_BITS-1:0] move_target_d;
  logic        [SpdW-1:0]     move_speed_d;
  logic signed [VelW-1:0]     velocity_d;

  srhp_step #(.POS_BITS(POS_BITS)) u_step (
    .phase_i              (phase_q),
    .station_i            (station_q),
    .status_i             (status_q),
    .actual_position_i    (pos_q),
    .receive_target_i     (receive_target),
    .squish_target_i      (squish_target),
    .core_target_i        (core_target),
    .home_backoff_steps_i (backoff_steps),
    .homing_speed_i       (homing_speed),
    .travel_speed_i       (travel_speed),
    .phase_o              (phase_d),
    .station_o            (station_d),
    .flags_o              (flags_d),
    .move_target_o        (move_target_d),
    .move_speed_limit_o   (move_speed_d),
    .velocity_value_o     (velocity_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SETUP;
      station_q <= ST_NONE;
    end else if (step) begin
      phase_q   <= phase_d;
      station_q <= station_d;
    end
  end

  // Result register
  phase_e                     out_phase_q;
  cmd_flags_t                 out_flags_q;
  logic signed [POS_BITS-1:0] out_target_q;
  logic        [SpdW-1:0]     out_speed_q;
  logic signed [VelW-1:0]     out_velocity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_phase_q    <= phase_d;
      out_flags_q    <= flags_d;
      out_target_q   <= move_target_d;
      out_speed_q    <= move_speed_d;
      out_velocity_q <= velocity_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.phase            = out_phase_q;
  assign out_o.move_issue       = out_flags_q.move_issue;
  assign out_o.move_target      = out_target_q;
  assign out_o.move_speed_limit = out_speed_q;
  assign out_o.velocity_issue   = out_flags_q.velocity_issue;
  assign out_o.velocity_value   = out_velocity_q;
  assign out_o.stall_arm_issue  = out_flags_q.stall_arm_issue;
  assign out_o.stall_arm_value  = out_flags_q.stall_arm_value;
  assign out_o.zero_issue       = out_flags_q.zero_issue;

  // Assertions
  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(step) |-> out_phase_q == phase_q)
    else $error("result phase differs from state register");

  a_zero_only_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_flags_q.zero_issue |-> out_phase_q == PH_STOPPED)
    else $error("zero command outside homing stop");

  a_unissued_move_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_flags_q.move_issue |-> out_target_q == '0 && out_speed_q == '0)
    else $error("move fields set without a move command");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input accepted with both registers full");

endmodule

`default_nettype wire

// ----- design/srhp_cfg.sv -----
// Configuration register file: station targets, backoff offset and speeds.
// Depends on srhp_pkg and the srhp_cfg_if interface.
`default_nettype none

module srhp_cfg #(
  parameter int unsigned POS_BITS = srhp_pkg::PosBitsDefault,
  parameter int unsigned DATA_W   = (POS_BITS > srhp_pkg::VelW) ? POS_BITS : srhp_pkg::VelW
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  srhp_cfg_if.sink                               cfg_i,
  output logic signed [POS_BITS-1:0]             receive_target_o,
  output logic signed [POS_BITS-1:0]             squish_target_o,
  output logic signed [POS_BITS-1:0]             core_target_o,
  output logic signed [POS_BITS-1:0]             home_backoff_steps_o,
  output logic signed [srhp_pkg::VelW-1:0]       homing_speed_o,
  output logic        [srhp_pkg::SpdW-1:0]       travel_speed_o
);
  import srhp_pkg::*;

  logic signed [POS_BITS-1:0] receive_q, squish_q, core_q, backoff_q;
  logic signed [VelW-1:0]     homing_q;
  logic        [SpdW-1:0]     travel_q;
  logic                       wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receive_q <= '0;
      squish_q  <= '0;
      core_q    <= '0;
      backoff_q <= '0;
      homing_q  <= '0;
      travel_q  <= '0;
    end else if (wr) begin
      case (cfg_i.index)
        REG_RECEIVE_TARGET: receive_q <= cfg_i.data[POS_BITS-1:0];
        REG_SQUISH_TARGET:  squish_q  <= cfg_i.data[POS_BITS-1:0];
        REG_CORE_TARGET:    core_q    <= cfg_i.data[POS_BITS-1:0];
        REG_BACKOFF_STEPS:  backoff_q <= cfg_i.data[POS_BITS-1:0];
        REG_HOMING_SPEED:   homing_q  <= cfg_i.data[VelW-1:0];
        REG_TRAVEL_SPEED:   travel_q  <= cfg_i.data[SpdW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign receive_target_o     = receive_q;
  assign squish_target_o      = squish_q;
  assign core_target_o        = core_q;
  assign home_backoff_steps_o = backoff_q;
  assign homing_speed_o       = homing_q;
  assign travel_speed_o       = travel_q;

endmodule

`default_nettype wire

// ----- design/srhp_step.sv -----
// Combinational phase sequencer: next phase, station request and motor commands.
// Depends on srhp_pkg.
`default_nettype none

module srhp_step #(
  parameter int unsigned POS_BITS = srhp_pkg::PosBitsDefault
) (
  input  wire srhp_pkg::phase_e              phase_i,
  input  wire srhp_pkg::station_e            station_i,
  input  wire srhp_pkg::status_t             status_i,
  input  wire logic signed [POS_BITS-1:0]    actual_position_i,
  input  wire logic signed [POS_BITS-1:0]    receive_target_i,
  input  wire logic signed [POS_BITS-1:0]    squish_target_i,
  input  wire logic signed [POS_BITS-1:0]    core_target_i,
  input  wire logic signed [POS_BITS-1:0]    home_backoff_steps_i,
  input  wire logic signed [srhp_pkg::VelW-1:0] homing_speed_i,
  input  wire logic        [srhp_pkg::SpdW-1:0] travel_speed_i,
  output srhp_pkg::phase_e                   phase_o,
  output srhp_pkg::station_e                 station_o,
  output srhp_pkg::cmd_flags_t               flags_o,
  output logic signed [POS_BITS-1:0]         move_target_o,
  output logic        [srhp_pkg::SpdW-1:0]   move_speed_limit_o,
  output logic signed [srhp_pkg::VelW-1:0]   velocity_value_o
);
  import srhp_pkg::*;

  station_e                req;
  station_e                cur;
  logic                    moving;
  logic                    go_station;
  logic signed [POS_BITS-1:0] station_target;
  phase_e                  station_phase;

  // Decode switches; both high keeps the last request.
  always_comb begin
    case ({status_i.select_a, status_i.select_b})
      2'b10:   req = ST_RECEIVE;
      2'b00:   req = ST_SQUISH;
      2'b01:   req = ST_CORE;
      default: req = station_i;
    endcase
  end

  always_comb begin
    case (req)
      ST_RECEIVE: begin
        station_target = receive_target_i;
        station_phase  = PH_TO_RECEIVE;
      end
      ST_SQUISH: begin
        station_target = squish_target_i;
        station_phase  = PH_TO_SQUISH;
      end
      default: begin
        station_target = core_target_i;
        station_phase  = PH_TO_CORE;
      end
    endcase
  end

  always_comb begin
    cur    = ST_NONE;
    moving = 1'b0;
    case (phase_i)
      PH_TO_RECEIVE: begin cur = ST_RECEIVE; moving = 1'b1; end
      PH_AT_RECEIVE: cur = ST_RECEIVE;
      PH_TO_SQUISH:  begin cur = ST_SQUISH; moving = 1'b1; end
      PH_AT_SQUISH:  cur = ST_SQUISH;
      PH_TO_CORE:    begin cur = ST_CORE; moving = 1'b1; end
      PH_AT_CORE:    cur = ST_CORE;
      default: ;
    endcase
  end

  always_comb begin
    phase_o            = phase_i;
    flags_o            = '0;
    move_target_o      = '0;
    move_speed_limit_o = '0;
    velocity_value_o   = '0;
    go_station         = 1'b0;
    case (phase_i)
      PH_SETUP: begin
        if (status_i.driver_ready) begin
          flags_o.move_issue = 1'b1;
          move_target_o      = actual_position_i + home_backoff_steps_i;
          move_speed_limit_o = BackoffSpeed;
          phase_o            = PH_BACKOFF;
        end
      end
      PH_BACKOFF: begin
        if (status_i.target_reached) begin
          flags_o.velocity_issue = 1'b1;
          velocity_value_o       = homing_speed_i;
          phase_o                = PH_ARM;
        end
      end
      PH_ARM: begin
        if (status_i.speed_reached) begin
          flags_o.stall_arm_issue = 1'b1;
          flags_o.stall_arm_value = 1'b1;
          phase_o                 = PH_SEEK;
        end
      end
      PH_SEEK: begin
        // Stall at home: stop, disarm, zero the counter.
        if (status_i.stall_seen) begin
          flags_o.velocity_issue  = 1'b1;
          flags_o.stall_arm_issue = 1'b1;
          flags_o.zero_issue      = 1'b1;
          phase_o                 = PH_STOPPED;
        end
      end
      PH_STOPPED: go_station = (req != ST_NONE);
      PH_TO_RECEIVE, PH_TO_SQUISH, PH_TO_CORE,
      PH_AT_RECEIVE, PH_AT_SQUISH, PH_AT_CORE: begin
        // Arrival wins over a new request.
        if (moving && status_i.target_reached) begin
          phase_o = phase_e'(phase_i + 4'd1);
        end else begin
          go_station = (req != ST_NONE) && (req != cur);
        end
      end
      default: ;  // unused codes hold and issue nothing
    endcase
    if (go_station) begin
      flags_o.move_issue = 1'b1;
      move_target_o      = station_target;
      move_speed_limit_o = travel_speed_i;
      phase_o            = station_phase;
    end
  end

  assign station_o = req;

endmodule

`default_nettype wire
